@@ hw/rtl/evr_pkg.sv @@
// shared types, constants and tables for the euler vector rotation unit
package evr_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int ANGLE_WIDTH  = 16;
    localparam int COEF_WIDTH   = 18;
    localparam int CORDIC_WIDTH = 33;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_WIDTH   = 5;
    localparam int MUL_STEPS    = 14;
    localparam int CFG_WIDTH    = 2;
    localparam int PROD_WIDTH   = COEF_WIDTH + COORD_WIDTH;
    localparam int RND_WIDTH    = COORD_WIDTH + 1;
    localparam int SUM_WIDTH    = COORD_WIDTH + 3;

    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [COEF_WIDTH-1:0]   Q16_ONE     = 18'sd65536;
    localparam logic signed [COEF_WIDTH-1:0]   Q16_MONE    = -18'sd65536;

    localparam logic [CFG_WIDTH-1:0] REG_ANGLE_X = 2'd0;
    localparam logic [CFG_WIDTH-1:0] REG_ANGLE_Y = 2'd1;
    localparam logic [CFG_WIDTH-1:0] REG_ANGLE_Z = 2'd2;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;
    typedef coef_t [8:0] coef_mat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_TRIG,
        ST_MUL,
        ST_FIN
    } coef_state_t;

    typedef struct packed {
        logic                  load;
        logic                  advance;
        logic [STEP_WIDTH-1:0] step;
    } lane_ctrl_t;

    function automatic logic signed [CORDIC_WIDTH-1:0] arctan_turns(
        input logic [STEP_WIDTH-1:0] i
    );
        logic signed [CORDIC_WIDTH-1:0] a;
        case (i)
            5'd0:  a = 33'sd536870912;
            5'd1:  a = 33'sd316933406;
            5'd2:  a = 33'sd167458907;
            5'd3:  a = 33'sd85004756;
            5'd4:  a = 33'sd42667331;
            5'd5:  a = 33'sd21354465;
            5'd6:  a = 33'sd10679838;
            5'd7:  a = 33'sd5340245;
            5'd8:  a = 33'sd2670163;
            5'd9:  a = 33'sd1335087;
            5'd10: a = 33'sd667544;
            5'd11: a = 33'sd333772;
            5'd12: a = 33'sd166886;
            5'd13: a = 33'sd83443;
            5'd14: a = 33'sd41722;
            5'd15: a = 33'sd20861;
            5'd16: a = 33'sd10430;
            5'd17: a = 33'sd5215;
            5'd18: a = 33'sd2608;
            5'd19: a = 33'sd1304;
            5'd20: a = 33'sd652;
            5'd21: a = 33'sd326;
            5'd22: a = 33'sd163;
            5'd23: a = 33'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic coef_t clamp_unit(input logic signed [SUM_WIDTH-1:0] v);
        coef_t r;
        if (v > SUM_WIDTH'(Q16_ONE))
            r = Q16_ONE;
        else if (v < SUM_WIDTH'(Q16_MONE))
            r = Q16_MONE;
        else
            r = v[COEF_WIDTH-1:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/evr_cordic.sv @@
// one cordic lane: cosine and sine of a binary angle, one step per cycle while advance is set
module evr_cordic
    import evr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lane_ctrl_t             ctrl,
    input  logic [ANGLE_WIDTH-1:0] angle,
    output coef_t                  cos_val,
    output coef_t                  sin_val
);

    logic signed [CORDIC_WIDTH-1:0] x_reg, y_reg, z_reg;
    logic signed [CORDIC_WIDTH-1:0] x_next, y_next, z_next;
    logic [1:0] q_reg, q_next;

    logic [31:0] theta;
    logic [ANGLE_WIDTH-1:0] angle_rnd;
    logic [1:0] q_new;
    logic [31:0] resid;
    logic signed [CORDIC_WIDTH-1:0] dx, dy;
    logic signed [CORDIC_WIDTH:0] xr, yr;
    coef_t cc, ss;

    assign theta     = {angle, {(32-ANGLE_WIDTH){1'b0}}};
    assign angle_rnd = angle + ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 3));
    assign q_new     = angle_rnd[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
    assign resid     = theta - {q_new, 30'b0};
    assign dx        = y_reg >>> ctrl.step;
    assign dy        = x_reg >>> ctrl.step;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        q_next = q_reg;
        if (ctrl.load)
        begin
            x_next = CORDIC_GAIN;
            y_next = '0;
            z_next = {resid[31], resid};
            q_next = q_new;
        end
        else if (ctrl.advance)
        begin
            if (!z_reg[CORDIC_WIDTH-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - arctan_turns(ctrl.step);
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + arctan_turns(ctrl.step);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign xr = ($signed({x_reg[CORDIC_WIDTH-1], x_reg}) + (CORDIC_WIDTH+1)'(8192)) >>> 14;
    assign yr = ($signed({y_reg[CORDIC_WIDTH-1], y_reg}) + (CORDIC_WIDTH+1)'(8192)) >>> 14;
    assign cc = clamp_unit(SUM_WIDTH'(xr));
    assign ss = clamp_unit(SUM_WIDTH'(yr));

    always_comb
    begin
        case (q_reg)
            2'd0:
            begin
                cos_val = cc;
                sin_val = ss;
            end
            2'd1:
            begin
                cos_val = -ss;
                sin_val = cc;
            end
            2'd2:
            begin
                cos_val = -cc;
                sin_val = -ss;
            end
            default:
            begin
                cos_val = ss;
                sin_val = -cc;
            end
        endcase
    end

endmodule

@@ hw/rtl/evr_coef.sv @@
// angle registers and sequencer that rebuilds the rotation matrix
module evr_coef
    import evr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_WIDTH-1:0]   cfg_index,
    input  logic [ANGLE_WIDTH-1:0] cfg_data,
    output logic                   busy,
    output coef_mat_t              coef
);

    coef_state_t state_reg, state_next;
    logic [STEP_WIDTH-1:0] step_reg, step_next;
    logic [ANGLE_WIDTH-1:0] ax_reg, ay_reg, az_reg, ax_next, ay_next, az_next;
    coef_mat_t coef_reg, coef_next;
    coef_t cx_reg, sx_reg, cy_reg, sy_reg, cz_reg, sz_reg;
    coef_t prod_reg [MUL_STEPS];
    coef_t cx_w, sx_w, cy_w, sy_w, cz_w, sz_w;
    coef_t op_a, op_b, qm;
    logic signed [2*COEF_WIDTH-1:0] mul_full;
    logic restart;
    lane_ctrl_t lane;

    assign restart = cfg_write && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y
                                   || cfg_index == REG_ANGLE_Z);

    always_comb
    begin
        ax_next = ax_reg;
        ay_next = ay_reg;
        az_next = az_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_ANGLE_X: ax_next = cfg_data;
                REG_ANGLE_Y: ay_next = cfg_data;
                REG_ANGLE_Z: az_next = cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        if (restart)
        begin
            state_next = ST_ROT;
            step_next  = '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE: ;
                ST_ROT:
                begin
                    if (step_reg == STEP_WIDTH'(CORDIC_STEPS - 1))
                    begin
                        state_next = ST_TRIG;
                        step_next  = '0;
                    end
                    else
                        step_next = step_reg + 1'b1;
                end
                ST_TRIG: state_next = ST_MUL;
                ST_MUL:
                begin
                    if (step_reg == STEP_WIDTH'(MUL_STEPS - 1))
                    begin
                        state_next = ST_FIN;
                        step_next  = '0;
                    end
                    else
                        step_next = step_reg + 1'b1;
                end
                ST_FIN: state_next = ST_IDLE;
                default: state_next = ST_IDLE;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        lane.load    = restart;
        lane.advance = (state_reg == ST_ROT);
        lane.step    = step_reg;
        busy         = (state_reg != ST_IDLE);
    end

    evr_cordic u_lane_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane),
        .angle   (ax_next),
        .cos_val (cx_w),
        .sin_val (sx_w)
    );

    evr_cordic u_lane_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane),
        .angle   (ay_next),
        .cos_val (cy_w),
        .sin_val (sy_w)
    );

    evr_cordic u_lane_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane),
        .angle   (az_next),
        .cos_val (cz_w),
        .sin_val (sz_w)
    );

    // operand schedule for the shared multiplier
    always_comb
    begin
        case (step_reg)
            5'd0:  begin op_a = sx_reg;      op_b = sy_reg; end
            5'd1:  begin op_a = cx_reg;      op_b = sy_reg; end
            5'd2:  begin op_a = cy_reg;      op_b = cz_reg; end
            5'd3:  begin op_a = cy_reg;      op_b = sz_reg; end
            5'd4:  begin op_a = cx_reg;      op_b = sz_reg; end
            5'd5:  begin op_a = prod_reg[0]; op_b = cz_reg; end
            5'd6:  begin op_a = cx_reg;      op_b = cz_reg; end
            5'd7:  begin op_a = prod_reg[0]; op_b = sz_reg; end
            5'd8:  begin op_a = sx_reg;      op_b = cy_reg; end
            5'd9:  begin op_a = sx_reg;      op_b = sz_reg; end
            5'd10: begin op_a = prod_reg[1]; op_b = cz_reg; end
            5'd11: begin op_a = sx_reg;      op_b = cz_reg; end
            5'd12: begin op_a = prod_reg[1]; op_b = sz_reg; end
            5'd13: begin op_a = cx_reg;      op_b = cy_reg; end
            default: begin op_a = '0;        op_b = '0;     end
        endcase
    end

    assign mul_full = (op_a * op_b + (2*COEF_WIDTH)'(32768)) >>> 16;
    assign qm       = mul_full[COEF_WIDTH-1:0];

    always_comb
    begin
        coef_next = coef_reg;
        if (state_reg == ST_FIN)
        begin
            coef_next[0] = clamp_unit(SUM_WIDTH'(prod_reg[2]));
            coef_next[1] = clamp_unit(-SUM_WIDTH'(prod_reg[3]));
            coef_next[2] = clamp_unit(SUM_WIDTH'(sy_reg));
            coef_next[3] = clamp_unit(SUM_WIDTH'(prod_reg[4]) + SUM_WIDTH'(prod_reg[5]));
            coef_next[4] = clamp_unit(SUM_WIDTH'(prod_reg[6]) - SUM_WIDTH'(prod_reg[7]));
            coef_next[5] = clamp_unit(-SUM_WIDTH'(prod_reg[8]));
            coef_next[6] = clamp_unit(SUM_WIDTH'(prod_reg[9]) - SUM_WIDTH'(prod_reg[10]));
            coef_next[7] = clamp_unit(SUM_WIDTH'(prod_reg[11]) + SUM_WIDTH'(prod_reg[12]));
            coef_next[8] = clamp_unit(SUM_WIDTH'(prod_reg[13]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ax_reg    <= '0;
            ay_reg    <= '0;
            az_reg    <= '0;
            coef_reg  <= {Q16_ONE, coef_t'(0), coef_t'(0), coef_t'(0), Q16_ONE,
                          coef_t'(0), coef_t'(0), coef_t'(0), Q16_ONE};
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            az_reg    <= az_next;
            coef_reg  <= coef_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TRIG)
        begin
            cx_reg <= cx_w;
            sx_reg <= sx_w;
            cy_reg <= cy_w;
            sy_reg <= sy_w;
            cz_reg <= cz_w;
            sz_reg <= sz_w;
        end
        if (state_reg == ST_MUL)
            prod_reg[step_reg[3:0]] <= qm;
    end

    assign coef = coef_reg;

    property p_rot_step;
        @(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROT |-> step_reg <= STEP_WIDTH'(CORDIC_STEPS - 1);
    endproperty
    a_rot_step: assert property (p_rot_step) else $error("cordic step out of range");

    property p_mul_step;
        @(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> step_reg <= STEP_WIDTH'(MUL_STEPS - 1);
    endproperty
    a_mul_step: assert property (p_mul_step) else $error("multiply step out of range");

    property p_coef_quiet;
        @(posedge clk) disable iff (!rst_n)
        !$past(state_reg == ST_FIN) |-> $stable(coef_reg);
    endproperty
    a_coef_quiet: assert property (p_coef_quiet) else $error("matrix changed outside rebuild");

endmodule

@@ hw/rtl/evr_datapath.sv @@
// four stage matrix-vector pipeline with rounding and saturation
module evr_datapath
    import evr_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  coef_mat_t                     coef,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] rotated_x,
    output logic signed [COORD_WIDTH-1:0] rotated_y,
    output logic signed [COORD_WIDTH-1:0] rotated_z
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;
    logic signed [COORD_WIDTH-1:0] vec_reg [3];
    logic signed [PROD_WIDTH-1:0]  prod_reg [9];
    logic signed [RND_WIDTH-1:0]   rnd_reg [9];
    logic signed [COORD_WIDTH-1:0] res_reg [3];
    logic signed [RND_WIDTH-1:0]   rnd_next [9];
    logic signed [COORD_WIDTH-1:0] res_next [3];

    localparam logic signed [SUM_WIDTH-1:0] SAT_HI = SUM_WIDTH'((64'sd1 <<< (COORD_WIDTH-1)) - 1);
    localparam logic signed [SUM_WIDTH-1:0] SAT_LO = -SAT_HI - SUM_WIDTH'(1);

    assign r4 = !v4_reg || out_ready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            logic [PROD_WIDTH-1:0] mag;
            logic [PROD_WIDTH-1:0] rm;
            mag = prod_reg[k][PROD_WIDTH-1] ? PROD_WIDTH'(-prod_reg[k])
                                             : PROD_WIDTH'(prod_reg[k]);
            rm  = (mag + PROD_WIDTH'(32768)) >> 16;
            rnd_next[k] = prod_reg[k][PROD_WIDTH-1] ? -$signed(rm[RND_WIDTH-1:0])
                                                     : $signed(rm[RND_WIDTH-1:0]);
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            logic signed [SUM_WIDTH-1:0] s;
            s = SUM_WIDTH'(rnd_reg[3*r]) + SUM_WIDTH'(rnd_reg[3*r+1])
                + SUM_WIDTH'(rnd_reg[3*r+2]);
            if (s > SAT_HI)
                res_next[r] = SAT_HI[COORD_WIDTH-1:0];
            else if (s < SAT_LO)
                res_next[r] = SAT_LO[COORD_WIDTH-1:0];
            else
                res_next[r] = s[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            vec_reg[0] <= coord_x;
            vec_reg[1] <= coord_y;
            vec_reg[2] <= coord_z;
        end
        if (r2 && v1_reg)
        begin
            for (int k = 0; k < 9; k++)
                prod_reg[k] <= PROD_WIDTH'(coef[k] * vec_reg[k % 3]);
        end
        if (r3 && v2_reg)
        begin
            for (int k = 0; k < 9; k++)
                rnd_reg[k] <= rnd_next[k];
        end
        if (r4 && v3_reg)
        begin
            for (int r = 0; r < 3; r++)
                res_reg[r] <= res_next[r];
        end
    end

    assign out_valid = v4_reg;
    assign rotated_x = res_reg[0];
    assign rotated_y = res_reg[1];
    assign rotated_z = res_reg[2];

endmodule

@@ hw/rtl/euler_vector_rotation_unit.sv @@
// top level of the euler vector rotation unit
// Rotates one vector per cycle by Rx*Ry*Rz built from three angle registers, unless the
// output stalls or a rebuild is running. A word passes through four pipeline stages (input
// register, nine 18x32 products, rounding, row sum with saturation), and out_valid rises once
// the word has reached the row sum register; a stalled output holds it there.
// Each write to an angle register restarts the matrix rebuild: the cordic steps of three parallel
// lanes, a capture of sine and cosine, the products on the shared coefficient multiplier and
// a load of the matrix, while in_ready stays low.
module euler_vector_rotation_unit
    import evr_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_WIDTH-1:0]          cfg_index,
    input  logic [ANGLE_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] rotated_x,
    output logic signed [COORD_WIDTH-1:0] rotated_y,
    output logic signed [COORD_WIDTH-1:0] rotated_z
);

    logic busy;
    logic pipe_ready;
    coef_mat_t coef;

    evr_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .coef      (coef)
    );

    evr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .in_valid  (in_valid && !busy),
        .in_ready  (pipe_ready),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rotated_x (rotated_x),
        .rotated_y (rotated_y),
        .rotated_z (rotated_z)
    );

    assign in_ready = pipe_ready && !busy;

    property p_write_busy;
        @(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y
                      || cfg_index == REG_ANGLE_Z) |=> busy;
    endproperty
    a_write_busy: assert property (p_write_busy) else $error("write did not start rebuild");

    property p_busy_block;
        @(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready;
    endproperty
    a_busy_block: assert property (p_busy_block) else $error("word taken during rebuild");

    property p_busy_cause;
        @(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(cfg_write);
    endproperty
    a_busy_cause: assert property (p_busy_cause) else $error("rebuild without a write");

endmodule

@@ tb/evr_checker.sv @@
// checker for the euler vector rotation unit: tracks angles, predicts rotated words, compares
`timescale 1ns / 1ps
module evr_checker
    import evr_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_WIDTH-1:0]          cfg_index,
    input  logic [ANGLE_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [COORD_WIDTH-1:0] rotated_x,
    input  logic signed [COORD_WIDTH-1:0] rotated_y,
    input  logic signed [COORD_WIDTH-1:0] rotated_z,
    output int                            errors,
    output int                            pending,
    output int                            checked
);

    typedef struct {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } vec_t;

    localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };
    localparam longint ONE = 65536;

    logic [ANGLE_WIDTH-1:0] ang_x, ang_y, ang_z;
    longint                 coef [9];
    vec_t                   rotated_q [$];

    assign pending = rotated_q.size();

    function automatic longint unit_clamp(input longint v);
        if (v > ONE)
            return ONE;
        if (v < -ONE)
            return -ONE;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    function automatic void cordic_trig(input logic [ANGLE_WIDTH-1:0] a,
                                        output longint c, output longint s);
        longint theta, q, r, z, x, y, dx, dy, cc, ss;
        theta = longint'(a) << (32 - ANGLE_WIDTH);
        q = ((theta + 64'h2000_0000) >> 30) & 3;
        r = (theta - (q << 30)) & 64'hFFFF_FFFF;
        z = (r >= 64'h8000_0000) ? r - 64'h1_0000_0000 : r;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATAN_TURNS[i];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN_TURNS[i];
            end
        end
        cc = unit_clamp((x + 8192) >>> 14);
        ss = unit_clamp((y + 8192) >>> 14);
        case (q)
            0: begin c = cc;  s = ss;  end
            1: begin c = -ss; s = cc;  end
            2: begin c = -cc; s = -ss; end
            default: begin c = ss; s = -cc; end
        endcase
    endfunction

    function automatic void rebuild_matrix();
        longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
        cordic_trig(ang_x, cx, sx);
        cordic_trig(ang_y, cy, sy);
        cordic_trig(ang_z, cz, sz);
        sxsy = qmul(sx, sy);
        cxsy = qmul(cx, sy);
        coef[0] = unit_clamp(qmul(cy, cz));
        coef[1] = unit_clamp(-qmul(cy, sz));
        coef[2] = unit_clamp(sy);
        coef[3] = unit_clamp(qmul(cx, sz) + qmul(sxsy, cz));
        coef[4] = unit_clamp(qmul(cx, cz) - qmul(sxsy, sz));
        coef[5] = unit_clamp(-qmul(sx, cy));
        coef[6] = unit_clamp(qmul(sx, sz) - qmul(cxsy, cz));
        coef[7] = unit_clamp(qmul(sx, cz) + qmul(cxsy, sz));
        coef[8] = unit_clamp(qmul(cx, cy));
    endfunction

    function automatic longint round_prod(input longint k, input longint v);
        logic   neg;
        longint mk, mv, p;
        neg = (k < 0) != (v < 0);
        mk = (k < 0) ? -k : k;
        mv = (v < 0) ? -v : v;
        p = (mk * mv + 32768) >>> 16;
        return neg ? -p : p;
    endfunction

    function automatic vec_t rotate_vec(input longint vx, input longint vy, input longint vz);
        vec_t   res;
        longint sum [3];
        for (int r = 0; r < 3; r++)
        begin
            sum[r] = round_prod(coef[r*3], vx) + round_prod(coef[r*3+1], vy)
                   + round_prod(coef[r*3+2], vz);
            if (sum[r] > 64'sd2147483647)
                sum[r] = 64'sd2147483647;
            if (sum[r] < -64'sd2147483648)
                sum[r] = -64'sd2147483648;
        end
        res.x = sum[0][COORD_WIDTH-1:0];
        res.y = sum[1][COORD_WIDTH-1:0];
        res.z = sum[2][COORD_WIDTH-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vec_t want;
        if (!rst_n)
        begin
            ang_x = '0;
            ang_y = '0;
            ang_z = '0;
            for (int i = 0; i < 9; i++)
                coef[i] = (i % 4 == 0) ? ONE : 0;
            rotated_q.delete();
            errors = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_write && cfg_index inside {REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z})
            begin
                if (cfg_index == REG_ANGLE_X)
                    ang_x = cfg_data;
                else if (cfg_index == REG_ANGLE_Y)
                    ang_y = cfg_data;
                else
                    ang_z = cfg_data;
                rebuild_matrix();
            end
            if (in_valid && in_ready)
                rotated_q.push_back(rotate_vec(coord_x, coord_y, coord_z));
            if (out_valid && out_ready)
            begin
                if (rotated_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word %0d %0d %0d", $time,
                             rotated_x, rotated_y, rotated_z);
                end
                else
                begin
                    want = rotated_q.pop_front();
                    checked++;
                    if (want.x !== rotated_x)
                    begin
                        errors++;
                        $display("%0t: rotated_x expected %0d got %0d", $time,
                                 want.x, rotated_x);
                    end
                    if (want.y !== rotated_y)
                    begin
                        errors++;
                        $display("%0t: rotated_y expected %0d got %0d", $time,
                                 want.y, rotated_y);
                    end
                    if (want.z !== rotated_z)
                    begin
                        errors++;
                        $display("%0t: rotated_z expected %0d got %0d", $time,
                                 want.z, rotated_z);
                    end
                end
            end
        end
    end

endmodule

@@ tb/tb.sv @@
// testbench top for the euler vector rotation unit: stimulus, idling phases and verdict
`timescale 1ns / 1ps
module tb;
    import evr_pkg::*;

    localparam logic [CFG_WIDTH-1:0] REG_UNUSED = 2'd3;
    localparam int PHASE_WORDS = 228;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [CFG_WIDTH-1:0]          cfg_index;
    logic [ANGLE_WIDTH-1:0]        cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [COORD_WIDTH-1:0] coord_x, coord_y, coord_z;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [COORD_WIDTH-1:0] rotated_x, rotated_y, rotated_z;
    int                            errors, pending, checked;
    int                            idle_pct, stall_pct, sent, settings;

    euler_vector_rotation_unit DUT (.*);

    evr_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_word(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        coord_x  <= x;
        coord_y  <= y;
        coord_z  <= z;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_WIDTH-1:0] idx, input logic [ANGLE_WIDTH-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_angles(input logic [15:0] ax, input logic [15:0] ay,
                              input logic [15:0] az);
        drain_results();
        write_reg(REG_ANGLE_X, ax);
        write_reg(REG_ANGLE_Y, ay);
        write_reg(REG_ANGLE_Z, az);
        cfg_write <= 1'b0;
        settings++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'(int'($urandom_range(2097152)) - 1048576);
            2: return 32'(int'($urandom_range(536870912)) - 268435456);
            default:
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
        endcase
    endfunction

    task automatic directed_words();
        send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000);
        send_word(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
        send_word(32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
        send_word(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        send_word(32'hFFFF_8000, 32'h0000_7FFF, 32'h5555_5555);
        send_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_word(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_word(32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0002);
    endtask

    initial
    begin
        logic [15:0] ang [8][3];
        ang[0] = '{16'h0000, 16'h0000, 16'h0000};
        ang[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        ang[2] = '{16'h4000, 16'h8000, 16'hC000};
        ang[3] = '{16'h2000, 16'hE000, 16'h6000};
        ang[4] = '{16'h0001, 16'h7FFF, 16'h8001};
        for (int i = 5; i < 8; i++)
            ang[i] = '{16'($urandom), 16'($urandom), 16'($urandom)};

        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        coord_x   = '0;
        coord_y   = '0;
        coord_z   = '0;
        idle_pct  = 0;
        stall_pct = 0;
        sent      = 0;
        settings  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();
        set_angles(16'h8000, 16'h8000, 16'h8000);
        directed_words();

        for (int p = 0; p < 8; p++)
        begin
            set_angles(ang[p][0], ang[p][1], ang[p][2]);
            if (p == 3)
            begin
                write_reg(REG_UNUSED, 16'($urandom));
                cfg_write <= 1'b0;
            end
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (n == PHASE_WORDS / 2)
                    drain_results();
                send_word(rand_coord(), rand_coord(), rand_coord());
            end
        end

        drain_results();
        $display("sent %0d vectors under %0d angle settings, %0d rotated words checked",
                 sent, settings, checked);
        $display("idling phases: none, sender 71%%, receiver 71%%, both 20%%");
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
